>>> hdl/dbc_pkg.sv
// DES constants, permutation tables and S-box functions.
// Used by the round cell and the top level; no dependencies.
package dbc_pkg;

  localparam int unsigned Rounds = 16;
  localparam int unsigned HalfBits = 28;

  typedef logic [27:0] half_t;
  typedef logic [47:0] subkey_t;

  // Rotate amounts per round, indexed 0..15.
  localparam logic [1:0] SHIFT_TAB [16] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  localparam logic [6:0] PC1_TAB [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4
  };

  localparam logic [6:0] PC2_TAB [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10,
    23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48,
    44,49,39,56,34,53, 46,42,50,36,29,32
  };

  localparam logic [6:0] IP_TAB [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7
  };

  localparam logic [6:0] FP_TAB [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25
  };

  localparam logic [6:0] E_TAB [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1
  };

  localparam logic [6:0] P_TAB [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25
  };

  localparam logic [3:0] S_TAB [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
      0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
      15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
      3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
      13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
      13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
      1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
      13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
      3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
      14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
      11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
      10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
      4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
      13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
      6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
      1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
      2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}
  };

  // Rotate a key half left by one or two.
  function automatic half_t rot_left(input half_t x, input logic [1:0] s);
    half_t r;
    r = (s == 2'd2) ? {x[25:0], x[27:26]} : {x[26:0], x[27]};
    return r;
  endfunction

  // Rotate a key half right by one or two (inverse schedule).
  function automatic half_t rot_right(input half_t x, input logic [1:0] s);
    half_t r;
    r = (s == 2'd2) ? {x[1:0], x[27:2]} : {x[0], x[27:1]};
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55 - i] = v[64 - PC1_TAB[i]];
    return r;
  endfunction

  function automatic subkey_t perm_pc2(input logic [55:0] v);
    subkey_t r;
    for (int i = 0; i < 48; i++) r[47 - i] = v[56 - PC2_TAB[i]];
    return r;
  endfunction

  function automatic logic [63:0] perm_ip(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63 - i] = v[64 - IP_TAB[i]];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63 - i] = v[64 - FP_TAB[i]];
    return r;
  endfunction

  // Feistel function: expand, mix key, S-boxes, P.
  function automatic logic [31:0] feistel(input logic [31:0] rr, input subkey_t k);
    logic [47:0] x;
    logic [5:0] ch;
    logic [31:0] s;
    logic [31:0] r;
    for (int i = 0; i < 48; i++) x[47 - i] = rr[32 - E_TAB[i]];
    x = x ^ k;
    for (int j = 0; j < 8; j++) begin
      ch = x[47 - 6 * j -: 6];
      s[31 - 4 * j -: 4] = S_TAB[j][{ch[5], ch[0], ch[4:1]}];
    end
    for (int i = 0; i < 32; i++) r[31 - i] = s[32 - P_TAB[i]];
    return r;
  endfunction

endpackage

>>> hdl/des_block_cipher_unit.sv
// DES block cipher top level: IP and PC-1 stage, 16 round cells, FP stage.
// Depends on dbc_pkg and dbc_round_cell.
// A start transfer passes the entry register, the 16 round cells and the done register in turn.
// Throughput: one block per cycle; busy never rises, set by the 16-cell round chain.
// Reset clears only the valid bits of the chain and done; data registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module des_block_cipher_unit
  import dbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] plain_block,
  input  logic [63:0] cipher_key,
  input  logic        encrypt_mode,
  output logic        done,
  output logic [63:0] result_block
);

  logic        v   [Rounds + 1];
  logic        enc [Rounds + 1];
  half_t       c   [Rounds + 1];
  half_t       d   [Rounds + 1];
  logic [31:0] l   [Rounds + 1];
  logic [31:0] r   [Rounds + 1];
  logic [55:0] cd_in;
  logic [63:0] ip_in;

  assign busy  = 1'b0;
  assign cd_in = perm_pc1(cipher_key);
  assign ip_in = perm_ip(plain_block);

  // Register the entry transfer after IP and PC-1.
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= start && !busy;
    end
    enc[0] <= encrypt_mode;
    c[0]   <= cd_in[55:28];
    d[0]   <= cd_in[27:0];
    l[0]   <= ip_in[63:32];
    r[0]   <= ip_in[31:0];
  end

  for (genvar g = 0; g < Rounds; g++) begin : g_round
    dbc_round_cell #(.STAGE(g)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (v[g]),
      .in_enc   (enc[g]),
      .in_c     (c[g]),
      .in_d     (d[g]),
      .in_l     (l[g]),
      .in_r     (r[g]),
      .out_valid(v[g + 1]),
      .out_enc  (enc[g + 1]),
      .out_c    (c[g + 1]),
      .out_d    (d[g + 1]),
      .out_l    (l[g + 1]),
      .out_r    (r[g + 1])
    );
  end

  // Swap halves, apply FP and strobe the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v[Rounds];
    end
    result_block <= perm_fp({r[Rounds], l[Rounds]});
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    v[Rounds] |-> $past(v[0], Rounds))
    else $error("round chain valid lost");
  a_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(v[Rounds]))
    else $error("done without finished round");
  a_key_back: assert property (@(posedge clk) disable iff (rst)
    v[Rounds] |-> (c[Rounds] == $past(c[0], Rounds)))
    else $error("key schedule did not close");

endmodule

>>> hdl/dbc_round_cell.sv
// One DES round stage: key schedule step and Feistel round, registered.
// Depends on dbc_pkg.
module dbc_round_cell
  import dbc_pkg::*;
#(
  parameter int unsigned STAGE = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_enc,
  input  half_t       in_c,
  input  half_t       in_d,
  input  logic [31:0] in_l,
  input  logic [31:0] in_r,
  output logic        out_valid,
  output logic        out_enc,
  output half_t       out_c,
  output half_t       out_d,
  output logic [31:0] out_l,
  output logic [31:0] out_r
);

  localparam logic [1:0] FwdShift = SHIFT_TAB[STAGE];
  // Decrypt walks the schedule backward: undo the shift of round Rounds - 1 - STAGE.
  localparam logic [1:0] RevShift = SHIFT_TAB[Rounds - 1 - STAGE];

  half_t   c_next;
  half_t   d_next;
  subkey_t key;

  // Encrypt rotates left before use; decrypt uses key then rotates right.
  always_comb begin
    if (in_enc) begin
      c_next = rot_left(in_c, FwdShift);
      d_next = rot_left(in_d, FwdShift);
      key    = perm_pc2({c_next, d_next});
    end else begin
      key    = perm_pc2({in_c, in_d});
      c_next = rot_right(in_c, RevShift);
      d_next = rot_right(in_d, RevShift);
    end
  end

  // Advance the round.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_enc <= in_enc;
    out_c   <= c_next;
    out_d   <= d_next;
    out_l   <= in_r;
    out_r   <= in_l ^ feistel(in_r, key);
  end

endmodule

>>> tb/sv/des_block_cipher_checker.sv
// Checker for the DES block cipher unit: predicts each block from its own DES model.
// Watches the start/busy and done channels; depends on dbc_pkg for table constants.
module des_block_cipher_checker
  import dbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] plain_block,
  input  logic [63:0] cipher_key,
  input  logic        encrypt_mode,
  input  logic        done,
  input  logic [63:0] result_block,
  output int          fail_count,
  output int          pending_blocks
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0] expected_blocks[$];

  // Pick bits of a width-w word, table entries counted from the MSB as 1.
  function automatic logic [63:0] pick_bits(input logic [63:0] v, input int w,
                                            input int n, input int idx[]);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < n; i++) r = {r[62:0], v[w - idx[i]]};
    return r;
  endfunction

  function automatic logic [31:0] round_mix(input logic [31:0] rr, input logic [47:0] k);
    int e_idx[];
    int p_idx[];
    logic [47:0] x;
    logic [5:0] ch;
    logic [31:0] s;
    e_idx = new[48];
    p_idx = new[32];
    foreach (e_idx[i]) e_idx[i] = E_TAB[i];
    foreach (p_idx[i]) p_idx[i] = P_TAB[i];
    x = pick_bits({32'd0, rr}, 32, 48, e_idx) ^ k;
    s = '0;
    for (int j = 0; j < 8; j++) begin
      ch = x[47 - 6 * j -: 6];
      s = {s[27:0], S_TAB[j][{ch[5], ch[0]} * 16 + ch[4:1]]};
    end
    return pick_bits({32'd0, s}, 32, 32, p_idx);
  endfunction

  function automatic logic [63:0] des_cipher(input logic [63:0] blk_in,
                                             input logic [63:0] key, input logic enc);
    int pc1_idx[];
    int pc2_idx[];
    int ip_idx[];
    int fp_idx[];
    logic [47:0] round_keys[16];
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    logic [63:0] blk;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] t;
    pc1_idx = new[56];
    pc2_idx = new[48];
    ip_idx = new[64];
    fp_idx = new[64];
    foreach (pc1_idx[i]) pc1_idx[i] = PC1_TAB[i];
    foreach (pc2_idx[i]) pc2_idx[i] = PC2_TAB[i];
    foreach (ip_idx[i]) ip_idx[i] = IP_TAB[i];
    foreach (fp_idx[i]) fp_idx[i] = FP_TAB[i];
    cd = pick_bits(key, 64, 56, pc1_idx);
    c = cd[55:28];
    d = cd[27:0];
    for (int i = 0; i < 16; i++) begin
      repeat (SHIFT_TAB[i]) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      round_keys[i] = pick_bits({8'd0, c, d}, 56, 48, pc2_idx);
    end
    blk = pick_bits(blk_in, 64, 64, ip_idx);
    l = blk[63:32];
    r = blk[31:0];
    for (int i = 0; i < 16; i++) begin
      t = l ^ round_mix(r, round_keys[enc ? i : 15 - i]);
      l = r;
      r = t;
    end
    return pick_bits({r, l}, 64, 64, fp_idx);
  endfunction

  assign pending_blocks = expected_blocks.size();

  // Predict on each input transfer, compare on each done strobe.
  always @(posedge clk) begin
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (start && !busy)
        expected_blocks.push_back(des_cipher(plain_block, cipher_key, encrypt_mode));
      if (done) begin
        if (expected_blocks.size() == 0) begin
          $error("result_block: none expected, actual %h", result_block);
          fail_count <= fail_count + 1;
        end else begin
          if (result_block !== expected_blocks[0]) begin
            $error("result_block: expected %h, actual %h", expected_blocks[0], result_block);
            fail_count <= fail_count + 1;
          end
          void'(expected_blocks.pop_front());
        end
      end
    end
  end
endmodule

>>> tb/sv/tb_des_block_cipher_unit.sv
// Testbench top for des_block_cipher_unit: drives blocks, keys and modes.
// Depends on the DUT, dbc_pkg and des_block_cipher_checker.
module tb_des_block_cipher_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] plain_block = '0;
  logic [63:0] cipher_key = '0;
  logic        encrypt_mode = 1'b0;
  logic        done;
  logic [63:0] result_block;
  int          fail_count;
  int          pending_blocks;
  int          idle_cycles;

  always #4 clk = ~clk;

  des_block_cipher_unit dut (.*);
  des_block_cipher_checker checker_i (.*);

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Drive one block and hold until the transfer happens.
  task automatic send_block(input logic [63:0] blk, input logic [63:0] key,
                            input logic enc, input bit allow_gap);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    start <= 1'b1;
    plain_block <= blk;
    cipher_key <= key;
    encrypt_mode <= enc;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] blk;
    logic [63:0] key;
    logic [63:0] weak_keys[4];
    weak_keys = '{64'h0101010101010101, 64'hFEFEFEFEFEFEFEFE,
                  64'h1F1F1F1F0E0E0E0E, 64'h01FE01FE01FE01FE};
    idle_cycles = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    // Directed: field extremes, both modes, weak and semi-weak keys, known vector.
    send_block(64'h0123456789ABCDEF, 64'h133457799BBCDFF1, 1'b1, 0);
    send_block(64'h85E813540F0AB405, 64'h133457799BBCDFF1, 1'b0, 0);
    for (int m = 0; m < 2; m++) begin
      send_block('0, '0, m[0], 0);
      send_block('1, '1, m[0], 0);
      send_block('0, '1, m[0], 0);
      send_block('1, '0, m[0], 0);
      send_block(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, m[0], 0);
      foreach (weak_keys[k]) send_block(rand64(), weak_keys[k], m[0], 0);
    end
    start <= 1'b0;
    // Drain fully once before random traffic.
    while (pending_blocks != 0) @(negedge clk);
    // Random: encrypt then decrypt of the same block, plus independent items.
    for (int n = 0; n < 550; n++) begin
      blk = rand64();
      key = rand64();
      if (n % 3 == 0) begin
        send_block(blk, key, 1'b1, n < 450);
        send_block(blk, key, 1'b0, n < 450);
        n++;
      end else begin
        send_block(blk, key, 1'($urandom_range(0, 1)), n < 450);
      end
    end
    start <= 1'b0;
    while (pending_blocks != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
